FILE: sv/e2c_pkg.sv
// Shared types, constants and month-length table for the epoch-to-calendar block.
package e2c_pkg;

  localparam int unsigned ACC_W       = 32;
  localparam int unsigned EPOCH_W     = 31;
  localparam int unsigned ZONE_W      = 16;
  localparam logic [15:0] ZONE_RESET  = 16'd28800;

  localparam logic [ACC_W-1:0] DAY_SECS       = 32'd86400;
  localparam logic [ACC_W-1:0] HOUR_SECS      = 32'd3600;
  localparam logic [ACC_W-1:0] MIN_SECS       = 32'd60;
  localparam logic [ACC_W-1:0] YEAR_DAYS      = 32'd365;
  localparam logic [ACC_W-1:0] LONG_YEAR_DAYS = 32'd366;

  localparam logic [10:0] FIRST_YEAR = 11'd1970;
  localparam logic [1:0]  FIRST_M4   = 2'd2;
  localparam logic [6:0]  FIRST_M100 = 7'd70;
  localparam logic [8:0]  FIRST_M400 = 9'd370;
  localparam logic [6:0]  LAST_M100  = 7'd99;
  localparam logic [8:0]  LAST_M400  = 9'd399;
  localparam logic [3:0]  LAST_MONTH = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_YEAR,
    ST_MONTH,
    ST_HOUR,
    ST_MIN
  } e2c_state_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
    logic [4:0] len;
    unique case (idx)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/e2c_subu.sv
// Shared compare-and-subtract unit used for every step of the conversion.
module e2c_subu (
  input  logic [e2c_pkg::ACC_W-1:0] a,
  input  logic [e2c_pkg::ACC_W-1:0] b,
  output logic                      ge,
  output logic [e2c_pkg::ACC_W-1:0] diff
);
  import e2c_pkg::*;

  logic [ACC_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[ACC_W];
  assign diff = wide[ACC_W-1:0];

endmodule

FILE: sv/e2c_seq.sv
// Sequencer and working registers: day division, year and month walk, time split.
module e2c_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [e2c_pkg::EPOCH_W-1:0] epoch_seconds,
  input  logic [e2c_pkg::ZONE_W-1:0]  zone_offset,
  output logic                        busy,
  output logic                        done,
  output logic [e2c_pkg::ACC_W-1:0]   sub_a,
  output logic [e2c_pkg::ACC_W-1:0]   sub_b,
  input  logic                        sub_ge,
  input  logic [e2c_pkg::ACC_W-1:0]   sub_diff,
  output logic [10:0]                 year_out,
  output logic [3:0]                  month_out,
  output logic [4:0]                  day_out,
  output logic [4:0]                  hour_out,
  output logic [5:0]                  minute_out,
  output logic [5:0]                  second_out
);
  import e2c_pkg::*;

  e2c_state_t state, state_next;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rest;
  logic [3:0]       cnt;
  logic [14:0]      quo;
  logic [16:0]      rem;
  logic [10:0]      year;
  logic [1:0]       m4;
  logic [6:0]       m100;
  logic [8:0]       m400;
  logic [3:0]       month;
  logic [4:0]       day;
  logic [4:0]       hour;
  logic [5:0]       minute;
  logic [5:0]       second;
  logic             leap;

  assign leap  = (m4 == 2'd0) && ((m100 != 7'd0) || (m400 == 9'd0));
  assign sub_a = acc;
  assign rest  = sub_ge ? sub_diff : acc;
  assign busy  = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    sub_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DAY;
      end
      ST_DAY: begin
        sub_b = DAY_SECS << cnt;
        if (cnt == 4'd0) state_next = ST_YEAR;
      end
      ST_YEAR: begin
        sub_b = leap ? LONG_YEAR_DAYS : YEAR_DAYS;
        if (!sub_ge) state_next = ST_MONTH;
      end
      ST_MONTH: begin
        sub_b = {27'd0, month_len(leap, month)};
        if (!(sub_ge && (month != LAST_MONTH))) state_next = ST_HOUR;
      end
      ST_HOUR: begin
        sub_b = HOUR_SECS << cnt;
        if (cnt == 4'd0) state_next = ST_MIN;
      end
      ST_MIN: begin
        sub_b = MIN_SECS << cnt;
        if (cnt == 4'd0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_MIN) && (cnt == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        acc <= {1'b0, epoch_seconds} + {{(ACC_W-ZONE_W){1'b0}}, zone_offset};
        cnt <= 4'd15;
        quo <= '0;
      end
      ST_DAY: begin
        quo <= {quo[13:0], sub_ge};
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          rem  <= rest[16:0];
          acc  <= {16'd0, quo, sub_ge};
          year <= FIRST_YEAR;
          m4   <= FIRST_M4;
          m100 <= FIRST_M100;
          m400 <= FIRST_M400;
        end else begin
          acc <= rest;
        end
      end
      ST_YEAR: begin
        if (sub_ge) begin
          acc  <= sub_diff;
          year <= year + 11'd1;
          m4   <= m4 + 2'd1;
          m100 <= (m100 == LAST_M100) ? 7'd0 : m100 + 7'd1;
          m400 <= (m400 == LAST_M400) ? 9'd0 : m400 + 9'd1;
        end else begin
          month <= 4'd0;
        end
      end
      ST_MONTH: begin
        if (sub_ge && (month != LAST_MONTH)) begin
          acc   <= sub_diff;
          month <= month + 4'd1;
        end else begin
          day  <= acc[4:0] + 5'd1;
          acc  <= {15'd0, rem};
          cnt  <= 4'd4;
          hour <= '0;
        end
      end
      ST_HOUR: begin
        acc  <= rest;
        hour <= {hour[3:0], sub_ge};
        cnt  <= (cnt == 4'd0) ? 4'd5 : cnt - 4'd1;
      end
      ST_MIN: begin
        acc    <= rest;
        minute <= {minute[4:0], sub_ge};
        cnt    <= cnt - 4'd1;
        if (cnt == 4'd0) second <= rest[5:0];
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign year_out   = year;
  assign month_out  = month + 4'd1;
  assign day_out    = day;
  assign hour_out   = hour;
  assign minute_out = minute;
  assign second_out = second;

endmodule

FILE: sv/epoch_seconds_to_calendar.sv
// Top level: epoch seconds plus zone offset to local calendar date and time.
// Conversion steps: 16 day-division steps, one per year walked from 1970 plus one,
// one per month walked plus one, then 5 hour and 6 minute steps.
// Throughput: one transaction at a time on one shared compare-and-subtract unit; start is
// taken again in the cycle done is high. The receiver cannot stall the result.
// Reset (rst, synchronous) returns to idle and sets the zone offset to 28800 s.
module epoch_seconds_to_calendar (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [e2c_pkg::EPOCH_W-1:0] epoch_seconds,
  input  logic                        zone_offset_we,
  input  logic [e2c_pkg::ZONE_W-1:0]  zone_offset_seconds,
  output logic                        done,
  output logic [10:0]                 year_out,
  output logic [3:0]                  month_out,
  output logic [4:0]                  day_out,
  output logic [4:0]                  hour_out,
  output logic [5:0]                  minute_out,
  output logic [5:0]                  second_out
);
  import e2c_pkg::*;

  logic [ZONE_W-1:0] zone_offset;
  logic [ACC_W-1:0]  sub_a;
  logic [ACC_W-1:0]  sub_b;
  logic [ACC_W-1:0]  sub_diff;
  logic              sub_ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= ZONE_RESET;
    end else if (zone_offset_we) begin
      zone_offset <= zone_offset_seconds;
    end
  end

  e2c_subu u_subu (
    .a    (sub_a),
    .b    (sub_b),
    .ge   (sub_ge),
    .diff (sub_diff)
  );

  e2c_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .epoch_seconds (epoch_seconds),
    .zone_offset   (zone_offset),
    .busy          (busy),
    .done          (done),
    .sub_a         (sub_a),
    .sub_b         (sub_b),
    .sub_ge        (sub_ge),
    .sub_diff      (sub_diff),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without a finished transaction");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for more than one cycle");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    done |-> month_out >= 4'd1 && month_out <= 4'd12 && hour_out <= 5'd23 &&
             minute_out <= 6'd59 && second_out <= 6'd59 && day_out != 5'd0)
    else $error("result field out of range");

endmodule
